FILE: hw/rtl/pfde_pkg.sv
// Package for the palette framebuffer draw engine: sizes, request codes,
// orientation codes and the default palette. No dependencies.
package pfde_pkg;

  localparam int ScreenWidthDef  = 176;
  localparam int ScreenHeightDef = 220;

  localparam logic [2:0] REQ_PIXEL = 3'd0;
  localparam logic [2:0] REQ_RECT  = 3'd1;
  localparam logic [2:0] REQ_FILL  = 3'd2;
  localparam logic [2:0] REQ_GLYPH = 3'd3;
  localparam logic [2:0] REQ_FONT  = 3'd4;
  localparam logic [2:0] REQ_PAL   = 3'd5;
  localparam logic [2:0] REQ_SYNC  = 3'd6;
  localparam logic [2:0] REQ_SCAN  = 3'd7;

  localparam logic [2:0] ORI_NONE   = 3'd0;
  localparam logic [2:0] ORI_SWAP   = 3'd1;
  localparam logic [2:0] ORI_ROT180 = 3'd2;
  localparam logic [2:0] ORI_ROT270 = 3'd3;
  localparam logic [2:0] ORI_MIRX   = 3'd4;
  localparam logic [2:0] ORI_MIRY   = 3'd5;

  localparam logic [2:0] ORI_RESET = ORI_SWAP;

  // default rgb565 palette
  function automatic logic [15:0] default_color(input logic [3:0] idx);
    case (idx)
      4'd0:  default_color = 16'h0000;
      4'd1:  default_color = 16'h1863;
      4'd2:  default_color = 16'h8C51;
      4'd3:  default_color = 16'hFFFF;
      4'd4:  default_color = 16'hF800;
      4'd5:  default_color = 16'h07E0;
      4'd6:  default_color = 16'h001F;
      4'd7:  default_color = 16'hFA49;
      4'd8:  default_color = 16'h4FE9;
      4'd9:  default_color = 16'h4A5F;
      4'd10: default_color = 16'hFFE0;
      4'd11: default_color = 16'h07FF;
      4'd12: default_color = 16'hF81F;
      4'd13: default_color = 16'h8C40;
      4'd14: default_color = 16'h0451;
      default: default_color = 16'h8811;
    endcase
  endfunction

endpackage

FILE: hw/rtl/pfde_map.sv
// Orientation mapping of one logical point to signed physical coordinates.
// Depends on pfde_pkg.
module pfde_map import pfde_pkg::*; #(
  parameter int ScreenWidth  = ScreenWidthDef,
  parameter int ScreenHeight = ScreenHeightDef
) (
  input  logic [2:0]        ori_i,
  input  logic [8:0]        x_i,
  input  logic [8:0]        y_i,
  output logic signed [9:0] px_o,
  output logic signed [9:0] py_o
);
  localparam logic signed [9:0] WM1 = 10'(ScreenWidth - 1);
  localparam logic signed [9:0] HM1 = 10'(ScreenHeight - 1);
  logic signed [9:0] xs, ys;
  assign xs = $signed({1'b0, x_i});
  assign ys = $signed({1'b0, y_i});

  // select the mapping by orientation
  always_comb begin
    case (ori_i)
      ORI_SWAP:   begin px_o = ys;       py_o = xs;       end
      ORI_ROT180: begin px_o = WM1 - xs; py_o = HM1 - ys; end
      ORI_ROT270: begin px_o = WM1 - ys; py_o = HM1 - xs; end
      ORI_MIRX:   begin px_o = WM1 - xs; py_o = ys;       end
      ORI_MIRY:   begin px_o = xs;       py_o = HM1 - ys; end
      default:    begin px_o = xs;       py_o = ys;       end
    endcase
  end
endmodule

FILE: hw/rtl/palette_framebuffer_draw_engine.sv
// Palette framebuffer draw engine top level: sequencer, buffers, font, palette.
// Pixel draws do a pixel pair read-modify-write per visited point: S_PT reads,
// S_PTW writes. Rect does the same per clipped point; fill writes each buffer
// byte, sync copies each byte into the display buffer; glyph: 128 points, each
// after a font row read, written only if set and on-screen; scan read registers
// the display byte into the output, input stalls while a result waits.
// After reset a clearing pass zeroes both buffers and the font store before the
// first request is taken. Depends on pfde_pkg and pfde_map.
module palette_framebuffer_draw_engine import pfde_pkg::*; #(
  parameter int ScreenWidth  = ScreenWidthDef,
  parameter int ScreenHeight = ScreenHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  x_a_i,
  input  logic [7:0]  y_a_i,
  input  logic [7:0]  x_b_i,
  input  logic [7:0]  y_b_i,
  input  logic [3:0]  color_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  table_row_i,
  input  logic [15:0] table_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_rgb_o,
  output logic [15:0] right_rgb_o,
  output logic        line_end_o,
  output logic        frame_end_o
);
  localparam int RowBytes = (ScreenWidth + 1) / 2;
  localparam int BufBytes = RowBytes * ScreenHeight;
  localparam int AW = $clog2(BufBytes + 1);
  localparam int FontDepth = 4096;
  localparam int ClrLen = (BufBytes > FontDepth) ? BufBytes : FontDepth;
  localparam int CW = $clog2(ClrLen + 1);
  localparam logic [AW-1:0] LAST = AW'(BufBytes - 1);
  localparam logic [AW-1:0] ROWB = AW'(RowBytes);
  localparam logic [7:0] RLAST = 8'(RowBytes - 1);
  localparam logic signed [9:0] WM1 = 10'(ScreenWidth - 1);
  localparam logic signed [9:0] HM1 = 10'(ScreenHeight - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PT    = 4'd2;  // map current point, read byte
  localparam logic [3:0] S_PTW   = 4'd3;  // modify and write byte
  localparam logic [3:0] S_FILL  = 4'd4;
  localparam logic [3:0] S_SYR   = 4'd5;
  localparam logic [3:0] S_SYW   = 4'd6;
  localparam logic [3:0] S_SCR   = 4'd7;
  localparam logic [3:0] S_SCW   = 4'd8;
  localparam logic [3:0] S_GFR   = 4'd9;  // read font row

  // configuration
  logic [2:0] ori_q;
  assign pready = 1'b1;
  assign prdata = {29'd0, ori_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ori_q <= ORI_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) ori_q <= pwdata[2:0];
  end

  // memories
  logic [7:0]  draw_mem [BufBytes];
  logic [7:0]  disp_mem [BufBytes];
  logic [7:0]  font_mem [FontDepth];
  logic [15:0] pal_q [16];

  logic [3:0] st_q;
  logic [CW-1:0] clr_q;
  logic [AW-1:0] ptr_q, dadr, sadr;
  logic [AW-1:0] scan_q;
  logic [7:0] drd_q, srd_q, frd_q;
  logic       dwe, swe, fwe;
  logic [7:0] dwd, swd, fwd;
  logic [11:0] fadr;
  logic [AW-1:0] wadr_q;

  always_ff @(posedge clk_i) begin
    if (dwe) draw_mem[dadr] <= dwd;
    drd_q <= draw_mem[dadr];
    if (swe) disp_mem[sadr] <= swd;
    srd_q <= disp_mem[sadr];
    if (fwe) font_mem[fadr] <= fwd;
    frd_q <= font_mem[fadr];
  end

  // request registers
  logic [2:0] req_q;
  logic [3:0] col_q;
  logic [7:0] xa_q, ya_q, code_q;
  logic [9:0] x0_q, x1_q, y1_q, cx_q, cy_q;  // rect bounds and current point (physical)
  logic [2:0] gx_q;
  logic [3:0] gy_q;
  logic       nib_q;
  logic       last_q;

  // rect corner mapping
  logic signed [9:0] ax, ay, bx, by;
  pfde_map #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_ma (
    .ori_i(ori_q), .x_i({1'b0, x_a_i}), .y_i({1'b0, y_a_i}), .px_o(ax), .py_o(ay));
  pfde_map #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_mb (
    .ori_i(ori_q), .x_i({1'b0, x_b_i}), .y_i({1'b0, y_b_i}), .px_o(bx), .py_o(by));

  // glyph point mapping
  logic signed [9:0] gpx, gpy;
  pfde_map #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_mg (
    .ori_i(ori_q), .x_i({1'b0, xa_q} + {6'd0, gx_q}),
    .y_i({1'b0, ya_q} + {5'd0, gy_q}), .px_o(gpx), .py_o(gpy));

  // current point: rect walker or glyph
  logic signed [9:0] cpx, cpy;
  logic inscr, gbit;
  logic [AW-1:0] cadr;
  assign cpx = (req_q == REQ_GLYPH) ? gpx : $signed(cx_q);
  assign cpy = (req_q == REQ_GLYPH) ? gpy : $signed(cy_q);
  assign gbit = frd_q[3'd7 - gx_q];
  assign inscr = (cpx >= 0) && (cpx <= WM1) && (cpy >= 0) && (cpy <= HM1) &&
                 ((req_q != REQ_GLYPH) || gbit);
  assign cadr = AW'(cpy[7:0]) * ROWB + AW'(cpx[8:1]);

  // last point of the walk
  logic pt_last;
  assign pt_last = (req_q == REQ_GLYPH) ? (gx_q == 3'd7 && gy_q == 4'd15)
                 : (req_q == REQ_PIXEL) ? 1'b1 : (cx_q == x1_q && cy_q == y1_q);

  logic res_pend_q;
  logic [3:0] nib_l_q, nib_r_q;
  logic le_q, fe_q;

  assign in_stall_o = (st_q != S_IDLE) || (out_valid_o && out_stall_i);
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // memory port control
  always_comb begin
    dadr = ptr_q; dwe = 1'b0; dwd = 8'd0;
    sadr = ptr_q; swe = 1'b0; swd = drd_q;
    fadr = {code_q, 4'd15 - gy_q}; fwe = 1'b0; fwd = 8'd0;
    case (st_q)
      S_CLR: begin
        dadr = clr_q[AW-1:0]; sadr = clr_q[AW-1:0]; fadr = clr_q[11:0];
        dwe = (clr_q < CW'(BufBytes)); swe = dwe; swd = 8'd0;
        fwe = (clr_q < CW'(FontDepth));
      end
      S_IDLE: begin
        fadr = {char_code_i, table_row_i}; fwd = table_data_i[7:0];
        fwe = acc && req_type_i == REQ_FONT;
        sadr = scan_q;
      end
      S_PT:  dadr = cadr;
      S_PTW: begin
        dadr = wadr_q; dwe = 1'b1;
        dwd = nib_q ? {drd_q[7:4], col_q} : {col_q, drd_q[3:0]};
      end
      S_FILL: begin dwe = 1'b1; dwd = {col_q, col_q}; end
      S_SYW: begin sadr = wadr_q; swe = 1'b1; end
      S_SCR: sadr = scan_q;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; scan_q <= '0; res_pend_q <= 1'b0;
      for (int i = 0; i < 16; i++) pal_q[i] <= default_color(4'(i));
      req_q <= REQ_PIXEL; col_q <= '0; xa_q <= '0; ya_q <= '0; code_q <= '0;
      gx_q <= '0; gy_q <= '0; ptr_q <= '0; wadr_q <= '0;
      cx_q <= '0; cy_q <= '0; x0_q <= '0; x1_q <= '0; y1_q <= '0;
      nib_q <= 1'b0; last_q <= 1'b0; nib_l_q <= '0; nib_r_q <= '0; fe_q <= 1'b0;
    end else begin
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(ClrLen - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          req_q <= req_type_i; col_q <= color_i; xa_q <= x_a_i; ya_q <= y_a_i;
          code_q <= char_code_i; gx_q <= '0; gy_q <= '0; ptr_q <= '0;
          case (req_type_i)
            REQ_PIXEL: begin cx_q <= ax; cy_q <= ay; st_q <= S_PT; end
            REQ_RECT: begin
              // sort, clip; empty if nothing visible
              automatic logic signed [9:0] lx, hx, ly, hy;
              lx = (ax < bx) ? ax : bx; hx = (ax < bx) ? bx : ax;
              ly = (ay < by) ? ay : by; hy = (ay < by) ? by : ay;
              if (lx < 0) lx = 0;
              if (ly < 0) ly = 0;
              if (hx > WM1) hx = WM1;
              if (hy > HM1) hy = HM1;
              cx_q <= lx; x0_q <= lx; cy_q <= ly; x1_q <= hx; y1_q <= hy;
              st_q <= (lx <= hx && ly <= hy) ? S_PT : S_IDLE;
            end
            REQ_FILL: st_q <= S_FILL;
            REQ_GLYPH: st_q <= S_GFR;
            REQ_PAL: pal_q[color_i] <= table_data_i;
            REQ_SYNC: begin st_q <= S_SYR; scan_q <= '0; end
            REQ_SCAN: st_q <= S_SCR;
            default: ;
          endcase
        end
        S_GFR: st_q <= S_PT;
        S_PT: begin
          wadr_q <= cadr; nib_q <= cpx[0]; last_q <= pt_last;
          st_q <= inscr ? S_PTW : (pt_last ? S_IDLE : S_PT);
          if (!inscr) begin
            if (req_q == REQ_GLYPH) begin
              if (gy_q == 4'd15) begin gy_q <= '0; gx_q <= gx_q + 1'b1; end
              else gy_q <= gy_q + 1'b1;
              if (!pt_last) st_q <= S_GFR;
            end else if (cx_q == x1_q) begin
              cx_q <= x0_q; cy_q <= cy_q + 1'b1;
            end else cx_q <= cx_q + 1'b1;
          end
        end
        S_PTW: begin
          if (last_q) st_q <= S_IDLE;
          else if (req_q == REQ_GLYPH) begin
            if (gy_q == 4'd15) begin gy_q <= '0; gx_q <= gx_q + 1'b1; end
            else gy_q <= gy_q + 1'b1;
            st_q <= S_GFR;
          end else begin
            st_q <= S_PT;
            if (cx_q == x1_q) begin cx_q <= x0_q; cy_q <= cy_q + 1'b1; end
            else cx_q <= cx_q + 1'b1;
          end
        end
        S_FILL: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST) st_q <= S_IDLE;
        end
        S_SYR: begin wadr_q <= ptr_q; ptr_q <= ptr_q + 1'b1; st_q <= S_SYW; end
        S_SYW: st_q <= (wadr_q == LAST) ? S_IDLE : S_SYR;
        S_SCR: st_q <= S_SCW;
        S_SCW: begin
          res_pend_q <= 1'b1;
          nib_l_q <= srd_q[7:4]; nib_r_q <= srd_q[3:0];
          fe_q <= (scan_q == LAST);
          scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
      if (out_valid_o && !out_stall_i && !(st_q == S_SCW)) res_pend_q <= 1'b0;
    end
  end

  // line-end tracking of the scan column
  logic [7:0] col_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      le_q <= 1'b0;
    end else if (st_q == S_IDLE && acc && req_type_i == REQ_SYNC) col_cnt_q <= '0;
    else if (st_q == S_SCW) begin
      le_q <= (col_cnt_q == RLAST);
      col_cnt_q <= (col_cnt_q == RLAST || scan_q == LAST) ? 8'd0 : col_cnt_q + 1'b1;
    end
  end

  // output stage, palette expansion
  assign out_valid_o = res_pend_q;
  assign left_rgb_o  = pal_q[nib_l_q];
  assign right_rgb_o = pal_q[nib_r_q];
  assign line_end_o  = le_q;
  assign frame_end_o = fe_q;

  // checks
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !acc) else $error("accept while busy");
  a_fe_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> line_end_o) else $error("frame end without line end");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_rgb_o))
    else $error("result lost");
endmodule
